### design/assert_macros.svh
// Shared assertion helpers for the separation force block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

### design/bsf_pkg.sv
package bsf_pkg;

	localparam int POS_W    = 24;
	localparam int OFF_W    = 25;
	localparam int LEN2_W   = 48;
	localparam int QUO_W    = 17;
	localparam int SUM_W    = 48;
	localparam int WGT_W    = 16;
	localparam int FORCE_W  = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 48;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 1'd1;

	localparam logic [LEN2_W-1:0] RADIUS_RESET = 48'd16777216;
	localparam logic signed [WGT_W-1:0] WEIGHT_RESET = 16'sd256;
	localparam logic [QUO_W-1:0] FACTOR_ONE = 17'd65536;

	typedef struct packed {
		logic signed [POS_W-1:0] self_x;
		logic signed [POS_W-1:0] self_y;
		logic signed [POS_W-1:0] self_z;
		logic signed [POS_W-1:0] other_x;
		logic signed [POS_W-1:0] other_y;
		logic signed [POS_W-1:0] other_z;
		logic                    neighbour_present;
		logic                    last;
	} item_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] force_x;
		logic signed [FORCE_W-1:0] force_y;
		logic signed [FORCE_W-1:0] force_z;
	} result_t;

	typedef struct packed {
		logic [LEN2_W-1:0]       radius_squared;
		logic signed [WGT_W-1:0] rule_weight;
	} cfg_t;

	// One classified neighbour handed from front to back
	typedef struct packed {
		logic signed [OFF_W-1:0] vx;
		logic signed [OFF_W-1:0] vy;
		logic signed [OFF_W-1:0] vz;
		logic [LEN2_W-1:0]       len2;
		logic                    hit;
		logic                    last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### design/boid_separation_force.sv
// Separation force: a front end forms the offset and squared length (skipping the
// squares for an empty neighbour word), stays busy until the word is handed over and
// queues it once the queue has room; a back end divides by the squared radius with a
// restoring divider and accumulates for a neighbour word in radius, skips one outside
// it, and emits on last; done lasts one cycle. Reset clears sums and queue, and loads
// a squared radius of 2^24 and weight 1.0.
`include "assert_macros.svh"

module boid_separation_force #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  bsf_pkg::item_t                    item,
	output logic                              done,
	output bsf_pkg::result_t                  result,
	input  logic                              cfg_we,
	input  logic [bsf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsf_pkg::CFG_DAT_W-1:0]     cfg_data
);

	bsf_pkg::cfg_t    cfg_q;
	bsf_pkg::q_stat_t q_stat;
	bsf_pkg::entry_t  push_entry;
	bsf_pkg::entry_t  head;
	logic push;
	logic pop;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius_squared <= bsf_pkg::RADIUS_RESET;
			cfg_q.rule_weight    <= bsf_pkg::WEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bsf_pkg::REG_RADIUS: cfg_q.radius_squared <= cfg_data[bsf_pkg::LEN2_W-1:0];
				bsf_pkg::REG_WEIGHT: cfg_q.rule_weight    <= cfg_data[bsf_pkg::WGT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.cfg        (cfg_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	bsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	bsf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_stat (q_stat),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "done held past one cycle")
	`ASSERT_ALWAYS(a_busy_on_start, clk, arst_n, $rose(busy) |-> $past(start), "busy without start")
	`ASSERT_NEXT(a_push_frees, clk, arst_n, push, !busy, "front still busy after handover")

endmodule

### design/bsf_front.sv
module bsf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  bsf_pkg::item_t   item,
	input  bsf_pkg::cfg_t    cfg,
	input  bsf_pkg::q_stat_t q_stat,
	output logic             push,
	output bsf_pkg::entry_t  push_entry
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SQ   = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] cnt_q;
	logic signed [bsf_pkg::OFF_W-1:0] v_q [3];
	logic present_q;
	logic last_q;
	logic [bsf_pkg::LEN2_W-1:0] sq_q;
	logic [bsf_pkg::LEN2_W+1:0] len2_q;
	logic signed [bsf_pkg::OFF_W-1:0] sel_v;
	logic signed [2*bsf_pkg::OFF_W-1:0] sq_full;
	logic accept;
	logic in_radius;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Pick the component to square this cycle
	always_comb begin
		case (cnt_q)
			2'd0: sel_v = v_q[0];
			2'd1: sel_v = v_q[1];
			2'd2: sel_v = v_q[2];
			default: sel_v = '0;
		endcase
	end

	assign sq_full = sel_v * sel_v;
	assign in_radius = (len2_q <= {2'b00, cfg.radius_squared});

	// Take the word, form the offset, then square and sum one axis a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						state_q <= item.neighbour_present ? ST_SQ : ST_PUSH;
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!q_stat.full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the payload of the word in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q[0]    <= {item.other_x[23], item.other_x} - {item.self_x[23], item.self_x};
			v_q[1]    <= {item.other_y[23], item.other_y} - {item.self_y[23], item.self_y};
			v_q[2]    <= {item.other_z[23], item.other_z} - {item.self_z[23], item.self_z};
			present_q <= item.neighbour_present;
			last_q    <= item.last;
			len2_q    <= '0;
		end else if (state_q == ST_SQ) begin
			sq_q <= sq_full[bsf_pkg::LEN2_W-1:0];
			if (cnt_q != 2'd0) begin
				len2_q <= len2_q + {2'b00, sq_q};
			end
		end
	end

	// Classify and hand over once the queue has room
	assign push = (state_q == ST_PUSH) && !q_stat.full;
	always_comb begin
		push_entry.vx   = v_q[0];
		push_entry.vy   = v_q[1];
		push_entry.vz   = v_q[2];
		push_entry.len2 = len2_q[bsf_pkg::LEN2_W-1:0];
		push_entry.hit  = present_q && in_radius;
		push_entry.last = last_q;
	end

endmodule

### design/bsf_queue.sv
`include "assert_macros.svh"

module bsf_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bsf_pkg::entry_t  push_entry,
	input  logic             pop,
	output bsf_pkg::entry_t  head,
	output bsf_pkg::q_stat_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	bsf_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == FULL_CNT);
	assign q_stat.empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	// Store the new word at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and track fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`ASSERT_ALWAYS(a_no_overflow, clk, arst_n, push |-> !q_stat.full, "push into full queue")
	`ASSERT_ALWAYS(a_no_underflow, clk, arst_n, pop |-> !q_stat.empty, "pop from empty queue")
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= FULL_CNT, "queue count past depth")

endmodule

### design/bsf_back.sv
module bsf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bsf_pkg::cfg_t    cfg,
	input  bsf_pkg::q_stat_t q_stat,
	input  bsf_pkg::entry_t  head,
	output logic             pop,
	output logic             done,
	output bsf_pkg::result_t result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_EMUL = 3'd4;
	localparam logic [2:0] ST_ESAT = 3'd5;

	localparam logic [4:0] DIV_LAST = 5'(bsf_pkg::QUO_W - 1);
	localparam int PROD_W  = bsf_pkg::OFF_W + bsf_pkg::QUO_W + 1;
	localparam int CONT_W  = PROD_W - 16;
	localparam int WPROD_W = bsf_pkg::SUM_W + bsf_pkg::WGT_W;
	localparam int P_W     = WPROD_W - 8;

	logic [2:0] state_q;
	logic [4:0] cnt_q;
	logic [1:0] k_q;
	bsf_pkg::entry_t ent_q;
	logic [bsf_pkg::LEN2_W:0] rem_q;
	logic [bsf_pkg::QUO_W-1:0] quo_q;
	logic [bsf_pkg::QUO_W-1:0] factor_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [WPROD_W-1:0] wprod_q;
	logic signed [bsf_pkg::SUM_W-1:0] sum_q [3];
	logic signed [bsf_pkg::FORCE_W-1:0] res_q [3];
	logic done_q;

	logic ge;
	logic [bsf_pkg::LEN2_W:0] rem_sub;
	logic [bsf_pkg::QUO_W-1:0] quo_next;
	logic signed [bsf_pkg::OFF_W-1:0] sel_v;
	logic signed [bsf_pkg::SUM_W-1:0] sel_sum;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [CONT_W-1:0] contrib;
	logic signed [bsf_pkg::SUM_W:0] diff;
	logic signed [bsf_pkg::SUM_W-1:0] sum_sat;
	logic signed [WPROD_W-1:0] wprod_rnd;
	logic signed [P_W-1:0] p;
	logic signed [bsf_pkg::FORCE_W-1:0] p_sat;

	assign pop = (state_q == ST_IDLE) && !q_stat.empty;

	// One restoring step of the quotient
	assign ge       = (rem_q >= {1'b0, cfg.radius_squared});
	assign rem_sub  = ge ? (rem_q - {1'b0, cfg.radius_squared}) : rem_q;
	assign quo_next = {quo_q[bsf_pkg::QUO_W-2:0], ge};

	// Pick the axis in work
	always_comb begin
		case (k_q)
			2'd0: begin
				sel_v   = ent_q.vx;
				sel_sum = sum_q[0];
			end
			2'd1: begin
				sel_v   = ent_q.vy;
				sel_sum = sum_q[1];
			end
			2'd2: begin
				sel_v   = ent_q.vz;
				sel_sum = sum_q[2];
			end
			default: begin
				sel_v   = '0;
				sel_sum = '0;
			end
		endcase
	end

	// Round the scaled offset and subtract it with saturation
	assign prod_rnd = prod_q + PROD_W'(32768);
	assign contrib  = prod_rnd[PROD_W-1:16];
	assign diff     = {sel_sum[bsf_pkg::SUM_W-1], sel_sum}
		- {{(bsf_pkg::SUM_W+1-CONT_W){contrib[CONT_W-1]}}, contrib};
	always_comb begin
		if (diff[bsf_pkg::SUM_W] != diff[bsf_pkg::SUM_W-1]) begin
			sum_sat = diff[bsf_pkg::SUM_W] ? {1'b1, {(bsf_pkg::SUM_W-1){1'b0}}}
				: {1'b0, {(bsf_pkg::SUM_W-1){1'b1}}};
		end else begin
			sum_sat = diff[bsf_pkg::SUM_W-1:0];
		end
	end

	// Round the weighted sum and clamp to the output range
	assign wprod_rnd = wprod_q + WPROD_W'(128);
	assign p         = wprod_rnd[WPROD_W-1:8];
	always_comb begin
		if (p[P_W-1:bsf_pkg::FORCE_W-1] != {(P_W-bsf_pkg::FORCE_W+1){p[P_W-1]}}) begin
			p_sat = p[P_W-1] ? {1'b1, {(bsf_pkg::FORCE_W-1){1'b0}}}
				: {1'b0, {(bsf_pkg::FORCE_W-1){1'b1}}};
		end else begin
			p_sat = p[bsf_pkg::FORCE_W-1:0];
		end
	end

	// Sequence divide, scale, accumulate and emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
			done_q  <= 1'b0;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			sum_q[2] <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						k_q   <= '0;
						cnt_q <= '0;
						if (head.hit) begin
							state_q <= ST_DIV;
						end else if (head.last) begin
							state_q <= ST_EMUL;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					sum_q[k_q] <= sum_sat;
					if (k_q == 2'd2) begin
						k_q     <= '0;
						state_q <= ent_q.last ? ST_EMUL : ST_IDLE;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_EMUL: begin
					state_q <= ST_ESAT;
				end
				ST_ESAT: begin
					sum_q[k_q] <= '0;
					if (k_q == 2'd2) begin
						k_q     <= '0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_EMUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the back end
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					ent_q <= head;
					rem_q <= {1'b0, head.len2};
					quo_q <= '0;
				end
			end
			ST_DIV: begin
				quo_q <= quo_next;
				rem_q <= {rem_sub[bsf_pkg::LEN2_W-1:0], 1'b0};
				if (cnt_q == DIV_LAST) begin
					factor_q <= (quo_next[bsf_pkg::QUO_W-1] && (quo_next != bsf_pkg::FACTOR_ONE))
						? '0 : bsf_pkg::FACTOR_ONE - quo_next;
				end
			end
			ST_MUL: begin
				prod_q <= sel_v * $signed({1'b0, factor_q});
			end
			ST_EMUL: begin
				wprod_q <= sel_sum * cfg.rule_weight;
			end
			ST_ESAT: begin
				res_q[k_q] <= p_sat;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign result.force_x = res_q[0];
	assign result.force_y = res_q[1];
	assign result.force_z = res_q[2];

endmodule

### sim/tb_boid_separation_force.sv
module tb_boid_separation_force;
	timeunit 1ns;
	timeprecision 1ps;
	import bsf_pkg::*;

	localparam int PHASES       = 10;
	localparam int PHASE_WORDS  = 140;
	localparam int DRAIN_CYCLES = 100;
	localparam int WATCHDOG     = 4000;
	localparam longint SUM_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_MIN  = -SUM_MAX - 1;
	localparam longint OUT_MAX  = 64'sh0000_0000_7FFF_FFFF;
	localparam longint OUT_MIN  = -OUT_MAX - 1;
	localparam logic [LEN2_W-1:0] RADIUS_MAX = 48'hFFFF_FFFF_FFFF;
	localparam int POS_MIN = -8388608;
	localparam int POS_MAX = 8388607;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	item_t                item;
	logic                 done;
	result_t              result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	// one row of the directed table: a register write or a word
	typedef struct {
		bit                   is_reg;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DAT_W-1:0] data;
		item_t                word;
		bit                   typed;
		result_t              force_out;
	} step_t;

	// predictor state
	logic [LEN2_W-1:0]       radius_sq;
	logic signed [WGT_W-1:0] weight;
	longint                  force_sum [3];
	result_t                 force_queue [$];

	// values handed to the monitor alongside the driven word
	bit      cur_typed;
	result_t cur_typed_force;

	int      failures;
	int      idle_cycles;
	int      burst_left;
	bit      steady;
	bit      progress;
	bit      emitted;
	result_t want;
	result_t calc;

	boid_separation_force dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// separation rule for one word; returns 1 when a force is emitted
	function automatic bit separation_step(input item_t w, output result_t f);
		longint      v [3];
		longint      c;
		longint      p;
		longint      factor;
		logic [63:0] len2;
		logic [63:0] q;
		f = '0;
		if (w.neighbour_present) begin
			v[0] = longint'(w.other_x) - longint'(w.self_x);
			v[1] = longint'(w.other_y) - longint'(w.self_y);
			v[2] = longint'(w.other_z) - longint'(w.self_z);
			len2 = 0;
			for (int k = 0; k < 3; k++)
				len2 += 64'(v[k] * v[k]);
			if (len2 <= {16'd0, radius_sq}) begin
				q = 0;
				if (radius_sq != 0)
					q = (len2 << 16) / {16'd0, radius_sq};
				if (q > 64'd65536)
					q = 64'd65536;
				factor = 65536 - longint'(q);
				for (int k = 0; k < 3; k++) begin
					c = (v[k] * factor + 32768) >>> 16;
					c = force_sum[k] - c;
					force_sum[k] = (c > SUM_MAX) ? SUM_MAX : ((c < SUM_MIN) ? SUM_MIN : c);
				end
			end
		end
		if (!w.last)
			return 1'b0;
		for (int k = 0; k < 3; k++) begin
			p = (force_sum[k] * longint'(weight) + 128) >>> 8;
			p = (p > OUT_MAX) ? OUT_MAX : ((p < OUT_MIN) ? OUT_MIN : p);
			case (k)
				0: f.force_x = 32'(p);
				1: f.force_y = 32'(p);
				default: f.force_z = 32'(p);
			endcase
			force_sum[k] = 0;
		end
		return 1'b1;
	endfunction

	// check results, predict accepted words, track register writes, watch for hangs
	always @(posedge clk) begin
		if (arst_n) begin
			progress = 1'b0;
			if (done) begin
				progress = 1'b1;
				if (force_queue.size() == 0) begin
					$error("force with none pending: %0d %0d %0d",
						result.force_x, result.force_y, result.force_z);
					failures++;
				end else begin
					want = force_queue.pop_front();
					if (result.force_x !== want.force_x) begin
						$error("force_x: expected %0d, got %0d", want.force_x, result.force_x);
						failures++;
					end
					if (result.force_y !== want.force_y) begin
						$error("force_y: expected %0d, got %0d", want.force_y, result.force_y);
						failures++;
					end
					if (result.force_z !== want.force_z) begin
						$error("force_z: expected %0d, got %0d", want.force_z, result.force_z);
						failures++;
					end
				end
			end
			if (start && !busy) begin
				progress = 1'b1;
				emitted = separation_step(item, calc);
				if (emitted)
					force_queue.push_back(cur_typed ? cur_typed_force : calc);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_RADIUS: radius_sq = cfg_data[LEN2_W-1:0];
					REG_WEIGHT: weight = cfg_data[WGT_W-1:0];
					default: ;
				endcase
			end
			idle_cycles = progress ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("** boid_separation_force: FAILED **");
				$finish;
			end
		end
	end

	function automatic step_t word_row(int sx, int sy, int sz, int ox, int oy, int oz,
		bit present, bit last, bit typed = 1'b0, result_t f = '0);
		step_t r;
		r.is_reg = 1'b0;
		r.index = '0;
		r.data = '0;
		r.word.self_x = sx[POS_W-1:0];
		r.word.self_y = sy[POS_W-1:0];
		r.word.self_z = sz[POS_W-1:0];
		r.word.other_x = ox[POS_W-1:0];
		r.word.other_y = oy[POS_W-1:0];
		r.word.other_z = oz[POS_W-1:0];
		r.word.neighbour_present = present;
		r.word.last = last;
		r.typed = typed;
		r.force_out = f;
		return r;
	endfunction

	function automatic step_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
		step_t r;
		r = word_row(0, 0, 0, 0, 0, 0, 1'b0, 1'b0);
		r.is_reg = 1'b1;
		r.index = idx;
		r.data = d;
		return r;
	endfunction

	// neighbour coordinate near p, offset magnitude up to 2^k, wrapping at 24 bits
	function automatic logic signed [POS_W-1:0] near(logic signed [POS_W-1:0] p, int k);
		int mag;
		int s;
		mag = $urandom_range(0, 1 << k);
		s = $urandom_range(0, 1) ? int'(p) - mag : int'(p) + mag;
		return s[POS_W-1:0];
	endfunction

	task automatic send_word(item_t w, bit typed, result_t f);
		@(negedge clk);
		start <= 1'b1;
		item <= w;
		cur_typed <= typed;
		cur_typed_force <= f;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic pause(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// bursts of words with random gaps, unless the phase runs steady
	task automatic pace();
		if (!steady && burst_left <= 0) begin
			pause($urandom_range(1, 20));
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
	endtask

	// hold off until every force has come and the block has gone quiet
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (force_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		step_t                   rows [$];
		item_t                   w;
		result_t                 sat;
		logic [LEN2_W-1:0]       r;
		logic signed [WGT_W-1:0] wt;
		logic [63:0]             raw;
		logic [31:0]             pick;
		logic signed [POS_W-1:0] sx;
		logic signed [POS_W-1:0] sy;
		logic signed [POS_W-1:0] sz;
		int                      bl;
		int                      kk;
		int                      len;
		int                      sent;
		bit                      full;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_typed = 1'b0;
		cur_typed_force = '0;
		radius_sq = RADIUS_RESET;
		weight = WEIGHT_RESET;
		for (int k = 0; k < 3; k++)
			force_sum[k] = 0;
		failures = 0;
		idle_cycles = 0;
		burst_left = 0;
		steady = 1'b0;

		// empty list, absent neighbours at the extremes, coincident neighbour
		rows.push_back(word_row(0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 1'b1));
		rows.push_back(word_row(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX,
			1'b0, 1'b1, 1'b1));
		rows.push_back(word_row(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN,
			1'b0, 1'b0));
		rows.push_back(word_row(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN,
			1'b1, 1'b1, 1'b1));
		// far outside the radius
		rows.push_back(word_row(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX,
			1'b1, 1'b1, 1'b1));
		rows.push_back(word_row(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN,
			1'b1, 1'b1, 1'b1));
		// inside, on the boundary, and just past it
		rows.push_back(word_row(0, 0, 0, 2048, 0, 0, 1'b1, 1'b1));
		rows.push_back(word_row(100, 200, 300, 1100, -300, 600, 1'b1, 1'b0));
		rows.push_back(word_row(0, 0, 0, -4096, 0, 0, 1'b1, 1'b0));
		rows.push_back(word_row(5, 5, 5, 5, 5, 6, 1'b1, 1'b1));
		rows.push_back(word_row(-700, 40, 9, -1500, 800, -9, 1'b1, 1'b0));
		rows.push_back(word_row(0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
		rows.push_back(word_row(0, 0, 0, 4096, 1, 0, 1'b1, 1'b1, 1'b1));
		// most negative weight
		rows.push_back(reg_row(REG_WEIGHT, 48'hFFFF_FFFF_8000));
		rows.push_back(word_row(0, 0, 0, 1000, -2000, 500, 1'b1, 1'b1));
		// zero radius: nothing but a coincident neighbour passes, and it adds nothing
		rows.push_back(reg_row(REG_RADIUS, 48'd0));
		rows.push_back(word_row(100, 200, 300, 100, 200, 300, 1'b1, 1'b1, 1'b1));
		rows.push_back(word_row(0, 0, 0, 1, 0, 0, 1'b1, 1'b1, 1'b1));
		// widest radius, top weight: the output saturates both ways
		rows.push_back(reg_row(REG_RADIUS, RADIUS_MAX));
		rows.push_back(reg_row(REG_WEIGHT, 48'h7FFF));
		sat.force_x = 32'sh7FFF_FFFF;
		sat.force_y = 32'sh7FFF_FFFF;
		sat.force_z = 32'sh8000_0000;
		for (int j = 0; j < 5; j++)
			rows.push_back(word_row(0, 0, 0, -4194304, -4194304, 4194304, 1'b1, j == 4,
				j == 4, sat));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// walk the directed table
		foreach (rows[i]) begin
			if (rows[i].is_reg) begin
				settle();
				write_reg(rows[i].index, rows[i].data);
			end else begin
				send_word(rows[i].word, rows[i].typed, rows[i].force_out);
			end
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: begin r = RADIUS_RESET; wt = WEIGHT_RESET; end
				1: begin r = RADIUS_MAX; wt = 16'sh7FFF; end
				2: begin r = 48'd1; wt = 16'sh8000; end
				3: begin r = 48'd0; wt = -16'sd1; end
				4: begin r = RADIUS_MAX; wt = 16'sh8000; end
				5: begin r = 48'h0100_0000_0000; wt = 16'sd0; end
				default: begin
					raw = {$urandom(), $urandom()};
					r = raw[LEN2_W-1:0] >> $urandom_range(0, 40);
					wt = raw[63:48];
				end
			endcase
			write_reg(REG_RADIUS, r);
			write_reg(REG_WEIGHT, 48'(wt));
			steady = (ph % 3 == 1);
			burst_left = 0;
			bl = 0;
			for (int b = 0; b < LEN2_W; b++)
				if (r[b])
					bl = b + 1;
			sent = 0;
			while (sent < PHASE_WORDS) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 4);
				full = ($urandom_range(0, 3) == 0);
				// pick one agent position for the whole list
				pick = full ? $urandom() : $urandom_range(0, 1 << 21) - (1 << 20);
				sx = pick[POS_W-1:0];
				pick = full ? $urandom() : $urandom_range(0, 1 << 21) - (1 << 20);
				sy = pick[POS_W-1:0];
				pick = full ? $urandom() : $urandom_range(0, 1 << 21) - (1 << 20);
				sz = pick[POS_W-1:0];
				for (int j = 0; j < len; j++) begin
					// offsets mostly around the radius, sometimes anywhere
					if ($urandom_range(0, 7) == 0)
						kk = $urandom_range(0, 24);
					else
						kk = bl / 2 - 2 + $urandom_range(0, 3);
					if (kk < 0)
						kk = 0;
					if (kk > 24)
						kk = 24;
					w.self_x = sx;
					w.self_y = sy;
					w.self_z = sz;
					w.other_x = near(sx, kk);
					w.other_y = near(sy, kk);
					w.other_z = near(sz, kk);
					w.neighbour_present = ($urandom_range(0, 9) != 0);
					w.last = (j == len - 1);
					pace();
					send_word(w, 1'b0, '0);
					sent++;
				end
			end
		end

		// drain and report
		@(negedge clk);
		start <= 1'b0;
		while (force_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && force_queue.size() == 0)
			$display("** boid_separation_force: PASSED **");
		else
			$display("** boid_separation_force: FAILED **");
		$finish;
	end

endmodule
